/* rtl/core/swh_pkg.sv */
// ----------------------------------------------------------------------------
// swh_pkg: shared types and constants
// Sizes for the significant wave height block: block length, top-third size,
// sum widths and the reciprocal used for the final division.
// ----------------------------------------------------------------------------
package swh_pkg;

    localparam int SAMPLES   = 20;
    localparam int DATA_W    = 16;
    localparam int TOP_N     = SAMPLES / 3;
    localparam int CNT_W     = $clog2(SAMPLES);
    localparam int SUM_W     = DATA_W + $clog2(TOP_N);
    localparam int ACC_CNT_W = $clog2(TOP_N + 1);

    // floor(sum / TOP_N) = (sum * RECIP) >> RECIP_SH, low by at most one
    localparam int RECIP_SH  = SUM_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / TOP_N);

    typedef logic [DATA_W-1:0] height_t;
    typedef logic [SUM_W-1:0]  sum_t;

    // handed from one cell to the next
    typedef struct packed {
        logic    keep;
        height_t value;
    } swh_link_t;

endpackage

/* rtl/core/swh_cell.sv */
// ----------------------------------------------------------------------------
// swh_cell: one slot of the insertion chain
// Holds one sample; keeps it, takes the new sample or takes its left
// neighbour's sample so that the chain stays in descending order.
// ----------------------------------------------------------------------------
module swh_cell (
    input  logic               clk,
    input  logic               load,
    input  swh_pkg::height_t   sample,
    input  logic               occupied,
    input  swh_pkg::swh_link_t left,
    output swh_pkg::swh_link_t right
);
    import swh_pkg::*;

    height_t value_reg;
    height_t value_next;
    logic    keep;

    // an occupied slot holding a value >= the new one stays put
    assign keep = occupied && (value_reg >= sample);

    always_comb
    begin
        value_next = value_reg;
        if (load && !keep)
        begin
            if (left.keep)
                value_next = sample;
            else
                value_next = left.value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign right.keep  = keep;
    assign right.value = value_reg;

endmodule

/* rtl/core/swh_accum.sv */
// ----------------------------------------------------------------------------
// swh_accum: top-third summer
// Captures the highest TOP_N samples into a shift line and adds them one a
// cycle.
// ----------------------------------------------------------------------------
module swh_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  swh_pkg::height_t              top [swh_pkg::TOP_N],
    output logic                          busy,
    output logic                          done,
    output swh_pkg::sum_t                 sum
);
    import swh_pkg::*;

    height_t              snap_reg [TOP_N];
    height_t              snap_next [TOP_N];
    logic [ACC_CNT_W-1:0] cnt_reg;
    logic [ACC_CNT_W-1:0] cnt_next;
    sum_t                 sum_reg;
    sum_t                 sum_next;
    logic                 done_reg;
    logic                 done_next;

    always_comb
    begin
        snap_next = snap_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        done_next = 1'b0;
        if (start)
        begin
            snap_next = top;
            cnt_next  = ACC_CNT_W'(TOP_N);
            sum_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            sum_next = sum_reg + SUM_W'(snap_reg[0]);
            for (int k = 0; k < TOP_N - 1; k++)
                snap_next[k] = snap_reg[k + 1];
            cnt_next  = cnt_reg - ACC_CNT_W'(1);
            done_next = (cnt_reg == ACC_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        sum_reg  <= sum_next;
    end

    assign busy = (cnt_reg != '0) || done_reg;
    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

/* rtl/core/swh_div.sv */
// ----------------------------------------------------------------------------
// swh_div: divide by TOP_N
// Reciprocal multiply, then one remainder check to correct the quotient.
// ----------------------------------------------------------------------------
module swh_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  swh_pkg::sum_t    sum,
    output logic             busy,
    output logic             out_valid,
    output swh_pkg::height_t quotient
);
    import swh_pkg::*;

    logic              v1_reg;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_reg;
    sum_t              sum1_reg;
    sum_t              sum2_reg;
    height_t           q2_reg;
    sum_t              rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sum) * PROD_W'(RECIP);
        sum1_reg <= sum;
        q2_reg   <= prod_reg[RECIP_SH +: DATA_W];
        sum2_reg <= sum1_reg;
    end

    // estimate is exact or one short
    assign rem       = sum2_reg - SUM_W'(q2_reg) * SUM_W'(TOP_N);
    assign quotient  = (rem >= SUM_W'(TOP_N)) ? q2_reg + DATA_W'(1) : q2_reg;
    assign out_valid = v2_reg;
    assign busy      = v1_reg || v2_reg;

endmodule

/* rtl/core/significant_wave_height.sv */
// ----------------------------------------------------------------------------
// significant_wave_height: H1/3 estimator over fixed blocks of samples
// Path: block end pulse, top-third summer, reciprocal divider, output register.
// Throughput: one sample word per cycle through the insertion chain; the last
// word of a block waits only while the previous block's result is undelivered.
// Reset: asynchronous, active low; clears the sample count and all valid flags.
// ----------------------------------------------------------------------------
module significant_wave_height (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [swh_pkg::DATA_W-1:0] s_tdata,   // [15:0] height
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [swh_pkg::DATA_W-1:0] m_tdata    // [15:0] significant_height
);
    import swh_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_pulse_reg;
    logic             load;
    logic             last_word;
    logic             busy;
    swh_link_t        link [SAMPLES + 1];
    height_t          top [TOP_N];
    logic             acc_busy;
    logic             acc_done;
    sum_t             acc_sum;
    logic             div_busy;
    logic             div_valid;
    height_t          div_q;
    logic             m_tvalid_reg;
    height_t          m_tdata_reg;

    assign last_word = (count_reg == CNT_W'(SAMPLES - 1));
    assign busy      = done_pulse_reg || acc_busy || div_busy || m_tvalid_reg;
    assign s_tready  = !(last_word && busy);
    assign load      = s_tvalid && s_tready;

    always_comb
    begin
        count_next = count_reg;
        if (load)
            count_next = last_word ? '0 : count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            done_pulse_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            done_pulse_reg <= load && last_word;
        end
    end

    // head of the chain always sees "insert here"
    assign link[0].keep  = 1'b1;
    assign link[0].value = s_tdata;

    for (genvar i = 0; i < SAMPLES; i++)
    begin : g_cell
        swh_cell u_cell (
            .clk      (clk),
            .load     (load),
            .sample   (s_tdata),
            .occupied (CNT_W'(i) < count_reg),
            .left     (link[i]),
            .right    (link[i + 1])
        );
    end

    for (genvar i = 0; i < TOP_N; i++)
    begin : g_top
        assign top[i] = link[i + 1].value;
    end

    swh_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (done_pulse_reg),
        .top   (top),
        .busy  (acc_busy),
        .done  (acc_done),
        .sum   (acc_sum)
    );

    swh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_done),
        .sum       (acc_sum),
        .busy      (div_busy),
        .out_valid (div_valid),
        .quotient  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (div_valid)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (div_valid)
            m_tdata_reg <= div_q;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // only one block result in flight anywhere in the back end
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({done_pulse_reg, acc_busy, div_busy, m_tvalid_reg}))
        else $error("more than one result in flight");

    // a completed block starts the summer on the next cycle
    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_word) |=> (done_pulse_reg && count_reg == '0))
        else $error("block end not handed to summer");

    // the divider never offers a word while the output still holds one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> !m_tvalid_reg)
        else $error("output word overrun");

endmodule
